/* rtl/dlfp_pkg.sv */
// ---------------------------------------------------------------------------
// dlfp_pkg
// shared widths, status codes and result type of the decimal list parser
// ---------------------------------------------------------------------------
`default_nettype none

package dlfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TDATA_W  = 56;
  localparam int unsigned PAD_W    = TDATA_W - VALUE_W - COUNT_W - STATUS_W;

  // result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HDR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_VALS  = 2'd3;

  // result kinds
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  typedef struct packed {
    logic                kind;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  // expected header character at a match position
  function automatic logic [BYTE_W-1:0] header_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h53;  // S
      3'd1:    c = 8'h54;  // T
      3'd2:    c = 8'h41;  // A
      3'd3:    c = 8'h52;  // R
      3'd4:    c = 8'h54;  // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // expected trailer character at a match position
  function automatic logic [BYTE_W-1:0] trailer_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h45;  // E
      3'd1:    c = 8'h4E;  // N
      3'd2:    c = 8'h44;  // D
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/decimal_list_frame_parser.sv */
// ---------------------------------------------------------------------------
// decimal_list_frame_parser
// parses a START-framed list of newline separated decimal numbers
// ---------------------------------------------------------------------------
// output: a result is written into the result queue when its byte word is accepted
// throughput: one byte word per cycle while two result queue slots are free; a byte
//   that yields two results (value and status) pushes both into the 4-entry result queue
// reset: rst (synchronous) returns the parser to header matching, clears the
//   count and empties the result queue
`default_nettype none

module decimal_list_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_message
  // results out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [30:0] parsed_value, [46:31] value_count,
                                           // [48:47] status, [55:49] zero
  output logic             m_axis_tuser,   // kind
  output logic             m_axis_tlast    // last_of_run
);

  // parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_SUFFIX = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_ERROR  = 3'd5;

  localparam logic [2:0] HDR_LEN = 3'd5;
  localparam logic [2:0] TRL_LEN = 3'd3;

  localparam logic [dlfp_pkg::VALUE_W-1:0] VALUE_MAX = {dlfp_pkg::VALUE_W{1'b1}};
  localparam logic [dlfp_pkg::COUNT_W-1:0] COUNT_MAX = {dlfp_pkg::COUNT_W{1'b1}};

  // parser state
  logic [2:0]                        phase, phase_next;
  logic [2:0]                        mpos, mpos_next;
  logic [dlfp_pkg::VALUE_W-1:0]      acc, acc_next;
  logic                              pend, pend_next;
  logic [dlfp_pkg::COUNT_W-1:0]      cnt, cnt_next;
  logic [dlfp_pkg::STATUS_W-1:0]     err, err_next;

  // result queue
  dlfp_pkg::result_t                 res_q [dlfp_pkg::QDEPTH];
  logic [dlfp_pkg::QPTR_W-1:0]       wptr, rptr;
  logic [dlfp_pkg::QCNT_W-1:0]       fill;

  logic                              in_fire, out_fire;
  logic                              do_body;
  logic                              emit_val;
  logic [1:0]                        n_push;
  logic [34:0]                       prod;
  logic [3:0]                        digit;
  logic [dlfp_pkg::STATUS_W-1:0]     st_code;
  logic [dlfp_pkg::STATUS_W-1:0]     err_fin;
  dlfp_pkg::result_t                 slot0, slot1, val_res, stat_res;

  // accept while two queue slots are free
  assign s_axis_tready = (fill <= dlfp_pkg::QCNT_W'(dlfp_pkg::QDEPTH - 2));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill != '0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // decimal step: acc * 10 + digit, with saturation below
  assign digit = s_axis_tdata[3:0];
  assign prod  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, digit};

  always_comb begin
    phase_next = phase;
    mpos_next  = mpos;
    acc_next   = acc;
    pend_next  = pend;
    cnt_next   = cnt;
    err_next   = err;
    do_body    = 1'b0;
    emit_val   = 1'b0;

    case (phase)
      PH_HEADER: begin
        if (mpos < HDR_LEN && s_axis_tdata == dlfp_pkg::header_char(mpos)) begin
          mpos_next = mpos + 3'd1;
          if (mpos + 3'd1 == HDR_LEN) phase_next = PH_SKIP;
        end else begin
          err_next   = dlfp_pkg::ST_BAD_HDR;
          phase_next = PH_ERROR;
        end
      end
      PH_SKIP: begin
        phase_next = PH_BODY;
      end
      PH_BODY: begin
        do_body = 1'b1;
      end
      PH_SUFFIX: begin
        if (mpos < TRL_LEN && s_axis_tdata == dlfp_pkg::trailer_char(mpos)) begin
          mpos_next = mpos + 3'd1;
          if (mpos + 3'd1 == TRL_LEN) phase_next = PH_DONE;
        end else if (mpos == 3'd0) begin
          do_body = 1'b1;
        end else begin
          err_next   = dlfp_pkg::ST_BAD_CHAR;
          phase_next = PH_ERROR;
        end
      end
      default: begin
      end
    endcase

    // body byte: newline, digit or bad character
    if (do_body) begin
      if (s_axis_tdata == dlfp_pkg::NEWLINE) begin
        if (pend) begin
          emit_val  = 1'b1;
          if (cnt != COUNT_MAX) cnt_next = cnt + 1'b1;
          acc_next  = '0;
          pend_next = 1'b0;
        end
        phase_next = PH_SUFFIX;
        mpos_next  = 3'd0;
      end else if (s_axis_tdata inside {[8'h30:8'h39]}) begin
        acc_next   = (prod[34:31] != 4'd0) ? VALUE_MAX : prod[30:0];
        pend_next  = 1'b1;
        phase_next = PH_BODY;
      end else begin
        err_next   = dlfp_pkg::ST_BAD_CHAR;
        phase_next = PH_ERROR;
      end
    end

    // end of message status, taken on the updated state
    err_fin = err_next;
    if (phase_next == PH_HEADER || phase_next == PH_SKIP) begin
      err_fin = dlfp_pkg::ST_BAD_HDR;
    end else if (phase_next == PH_SUFFIX && mpos_next != 3'd0 &&
                 err_next == dlfp_pkg::ST_OK) begin
      err_fin = dlfp_pkg::ST_BAD_CHAR;   // partial trailer
    end
    if (err_fin != dlfp_pkg::ST_OK) st_code = err_fin;
    else if (cnt_next == '0)        st_code = dlfp_pkg::ST_NO_VALS;
    else                            st_code = dlfp_pkg::ST_OK;

    val_res.kind    = dlfp_pkg::KIND_VALUE;
    val_res.value   = acc;
    val_res.count   = cnt_next;
    val_res.status  = dlfp_pkg::ST_OK;
    val_res.last    = 1'b0;

    stat_res.kind   = dlfp_pkg::KIND_STATUS;
    stat_res.value  = '0;
    stat_res.count  = cnt_next;
    stat_res.status = st_code;
    stat_res.last   = 1'b1;

    slot0  = emit_val ? val_res : stat_res;
    slot1  = stat_res;
    n_push = {1'b0, emit_val} + {1'b0, s_axis_tlast};

    // final byte returns the parser to its reset state
    if (s_axis_tlast) begin
      phase_next = PH_HEADER;
      mpos_next  = 3'd0;
      acc_next   = '0;
      pend_next  = 1'b0;
      cnt_next   = '0;
      err_next   = dlfp_pkg::ST_OK;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      mpos  <= 3'd0;
      acc   <= '0;
      pend  <= 1'b0;
      cnt   <= '0;
      err   <= dlfp_pkg::ST_OK;
    end else if (in_fire) begin
      phase <= phase_next;
      mpos  <= mpos_next;
      acc   <= acc_next;
      pend  <= pend_next;
      cnt   <= cnt_next;
      err   <= err_next;
    end
  end

  // result queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (in_fire) wptr <= wptr + dlfp_pkg::QPTR_W'(n_push);
      if (out_fire) rptr <= rptr + 1'b1;
      fill <= fill + (in_fire ? dlfp_pkg::QCNT_W'(n_push) : '0)
                   - (out_fire ? dlfp_pkg::QCNT_W'(1) : '0);
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_fire && n_push != 2'd0) res_q[wptr] <= slot0;
    if (in_fire && n_push == 2'd2) res_q[wptr + 1'b1] <= slot1;
  end

  assign m_axis_tdata = {{dlfp_pkg::PAD_W{1'b0}}, res_q[rptr].status,
                         res_q[rptr].count, res_q[rptr].value};
  assign m_axis_tuser = res_q[rptr].kind;
  assign m_axis_tlast = res_q[rptr].last;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= dlfp_pkg::QCNT_W'(dlfp_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tlast) |=> (phase == PH_HEADER && mpos == 3'd0 && cnt == '0))
    else $error("parser not reset after final byte");

  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
    else $error("status result and last flag disagree");

  a_acc_pending: assert property (@(posedge clk) disable iff (rst)
    (acc != '0) |-> pend)
    else $error("accumulator holds digits without pending flag");
`endif

endmodule

`default_nettype wire

/* tb/tb_decimal_list_frame_parser.sv */
// ---------------------------------------------------------------------------
// tb_decimal_list_frame_parser
// streams byte messages into the parser and compares every result word
// against a cycle-free model of the framing, digit and status rules
// ---------------------------------------------------------------------------
`default_nettype none

module tb_decimal_list_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BYTE_TARGET    = 750;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // -------------------------------------------------------------------------
  // scoreboard: mirrors the parser state and holds the results still due
  // -------------------------------------------------------------------------
  class parse_scoreboard;
    typedef enum logic [2:0] {
      PH_HEADER, PH_SKIP, PH_BODY, PH_TRAILER, PH_DONE, PH_ERROR
    } phase_e;

    phase_e                        phase;
    logic [2:0]                    pos;
    logic [dlfp_pkg::VALUE_W-1:0]  acc;
    bit                            digits_seen;
    logic [dlfp_pkg::COUNT_W-1:0]  count;
    logic [dlfp_pkg::STATUS_W-1:0] err;
    dlfp_pkg::result_t             results_due[$];
    int                            errors;
    string                         header_txt;
    string                         trailer_txt;

    function new();
      header_txt  = "START";
      trailer_txt = "END";
      errors      = 0;
      restart();
    endfunction

    function void restart();
      phase       = PH_HEADER;
      pos         = '0;
      acc         = '0;
      digits_seen = 1'b0;
      count       = '0;
      err         = dlfp_pkg::ST_OK;
    endfunction

    task report(input string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void abort(input logic [dlfp_pkg::STATUS_W-1:0] code);
      err   = code;
      phase = PH_ERROR;
    endfunction

    // digit, newline or anything else inside the list body
    function void body_byte(input logic [7:0] b);
      dlfp_pkg::result_t r;
      logic [63:0]       wide;
      if (b == dlfp_pkg::NEWLINE) begin
        if (digits_seen) begin
          if (count != '1) count = count + 1'b1;
          r.kind   = dlfp_pkg::KIND_VALUE;
          r.value  = acc;
          r.count  = count;
          r.status = dlfp_pkg::ST_OK;
          r.last   = 1'b0;
          results_due.push_back(r);
          acc         = '0;
          digits_seen = 1'b0;
        end
        phase = PH_TRAILER;
        pos   = '0;
      end else if (b >= 8'h30 && b <= 8'h39) begin
        wide = 64'(acc) * 64'd10 + 64'(b - 8'h30);
        acc  = (wide > 64'h7FFF_FFFF) ? '1 : wide[dlfp_pkg::VALUE_W-1:0];
        digits_seen = 1'b1;
        phase       = PH_BODY;
      end else begin
        abort(dlfp_pkg::ST_BAD_CHAR);
      end
    endfunction

    // one accepted byte word
    function void parse_byte(input logic [7:0] b, input logic eom);
      dlfp_pkg::result_t r;
      case (phase)
        PH_HEADER: begin
          if (b == header_txt[pos]) begin
            pos = pos + 1'b1;
            if (pos == 3'd5) phase = PH_SKIP;
          end else begin
            abort(dlfp_pkg::ST_BAD_HDR);
          end
        end
        PH_SKIP: phase = PH_BODY;
        PH_BODY: body_byte(b);
        PH_TRAILER: begin
          if (b == trailer_txt[pos]) begin
            pos = pos + 1'b1;
            if (pos == 3'd3) phase = PH_DONE;
          end else if (pos == 3'd0) begin
            body_byte(b);
          end else begin
            abort(dlfp_pkg::ST_BAD_CHAR);
          end
        end
        default: ;
      endcase

      if (eom) begin
        // ended inside the header or right after it
        if (phase == PH_HEADER || phase == PH_SKIP) err = dlfp_pkg::ST_BAD_HDR;
        // ended partway through the trailer
        if (phase == PH_TRAILER && pos != 3'd0 && err == dlfp_pkg::ST_OK)
          err = dlfp_pkg::ST_BAD_CHAR;
        r.kind   = dlfp_pkg::KIND_STATUS;
        r.value  = '0;
        r.count  = count;
        r.status = (err != dlfp_pkg::ST_OK) ? err :
                   ((count == '0) ? dlfp_pkg::ST_NO_VALS : dlfp_pkg::ST_OK);
        r.last   = 1'b1;
        results_due.push_back(r);
        restart();
      end
    endfunction

    task compare_result(input dlfp_pkg::result_t got);
      dlfp_pkg::result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result word kind=%0b count=%0d with nothing due",
                         got.kind, got.count));
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0b, expected %0b", got.kind, want.kind));
        if (got.value !== want.value)
          report($sformatf("value %0d, expected %0d", got.value, want.value));
        if (got.count !== want.count)
          report($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  // -------------------------------------------------------------------------
  // clock, reset and block signals
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0; // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // [30:0] parsed_value, [46:31] value_count,
                                    // [48:47] status, [55:49] zero
  logic        m_axis_tuser;        // kind
  logic        m_axis_tlast;        // last_of_run

  always #6 clk = ~clk;

  decimal_list_frame_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  parse_scoreboard sb = new();

  logic [7:0] msg[$];      // bytes of the message being sent
  bit         quiet;       // no idling on either side while set
  int         bytes_sent;
  int         idle_cycles = 0;

  // mostly back to back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endfunction

  function automatic void add_digits(input int n, input bit all_nines);
    repeat (n) msg.push_back(all_nines ? 8'h39 : 8'(8'h30 + $urandom_range(0, 9)));
  endfunction

  // -------------------------------------------------------------------------
  // random message: mostly well framed lists, some broken framing and noise
  // -------------------------------------------------------------------------
  function automatic void make_message();
    int    r;
    int    k;
    int    lines;
    string hdr;
    hdr = "START";
    msg.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // pure noise, any byte value
      k = $urandom_range(1, 10);
      repeat (k) msg.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (r < 16) begin
      // header cut short, maybe followed by one to three random bytes
      k = $urandom_range(0, 4);
      if (k > 0) add_text(hdr.substr(0, k - 1));
      if (k == 0 || $urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
      end
      return;
    end
    add_text("START");
    if (r < 19) return;                       // exactly the header
    msg.push_back(8'($urandom_range(0, 255))); // skipped byte
    lines = $urandom_range(0, 5);
    repeat (lines) begin
      if ($urandom_range(0, 9) == 0)
        add_digits($urandom_range(9, 12), $urandom_range(0, 1) == 1);
      else add_digits($urandom_range(0, 4), 1'b0);
      msg.push_back(dlfp_pkg::NEWLINE);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        add_text("END");
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
        end
      end
      5: add_text("E");
      6: add_text("EN");
      7: begin
        add_text("EN");
        msg.push_back(8'($urandom_range(0, 255)));
      end
      8: add_digits($urandom_range(1, 4), 1'b0);  // pending digits at the end
      default: ;
    endcase
    // a stray byte somewhere
    if ($urandom_range(0, 9) == 0)
      msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
    // message cut off early
    if ($urandom_range(0, 9) == 0 && msg.size() > 1)
      msg = msg[0:$urandom_range(0, msg.size() - 2)];
  endfunction

  // -------------------------------------------------------------------------
  // input side
  // -------------------------------------------------------------------------
  task send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eom;
    do @(posedge clk); while (!s_axis_tready);
    sb.parse_byte(b, eom);
    bytes_sent++;
  endtask

  task drive_message();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  initial begin
    quiet      = 1'b0;
    bytes_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short directed set: header mismatch, value saturation plus ignored
    // bytes after the trailer, and a one-byte message
    msg.delete();
    add_text("SX");
    drive_message();
    msg.delete();
    add_text("START#9999999999");
    msg.push_back(dlfp_pkg::NEWLINE);
    add_text("END!");
    drive_message();
    msg.delete();
    msg.push_back(8'hFF);
    drive_message();

    // random messages, some of them without any idling
    while (bytes_sent < BYTE_TARGET) begin
      make_message();
      quiet = ($urandom_range(0, 4) == 0);
      drive_message();
    end
    quiet = 1'b0;
    msg.delete();

    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    // drain, then keep watching for stray words
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // output side: random stall stretches, check every accepted word
  // -------------------------------------------------------------------------
  initial begin
    int                stall;
    dlfp_pkg::result_t got;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind   = m_axis_tuser;
        got.value  = m_axis_tdata[30:0];
        got.count  = m_axis_tdata[46:31];
        got.status = m_axis_tdata[48:47];
        got.last   = m_axis_tlast;
        sb.compare_result(got);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) stall = pick_gap();
      end
    end
  end

  // -------------------------------------------------------------------------
  // watchdog: too long without a word moving on either side
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/dlfp_pkg.sv
rtl/decimal_list_frame_parser.sv
tb/tb_decimal_list_frame_parser.sv
